[src/rrqs_pkg.sv]
// Shared types and constants for the round-robin quantum scheduler.
package rrqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int PID_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ENT_W     = 48;

  localparam logic [15:0] QUANTUM_RST = 16'd4;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } entry_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  process_id;
    logic [31:0] slice_end_time;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
    logic [39:0] total_turnaround;
    logic [39:0] total_waiting;
    logic [4:0]  process_count;
  } out_item_t;

  // Candidate tracking handed from the scan unit to the sequencer.
  typedef struct packed {
    logic             found;
    logic [PID_W-1:0] sel_idx;
    entry_t           sel_ent;
    logic             min_vld;
    logic [PID_W-1:0] min_idx;
    entry_t           min_ent;
  } scan_res_t;

endpackage

[src/round_robin_quantum_scheduler_core.sv]
// Top level: round-robin scheduler with time quantum, process table in RAM.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/in_stall   | in_item_t  (func, arrival, burst)
//   out_    | output    | out_valid/out_stall | out_item_t (slice report, totals)
//   cfg_    | input     | cfg_valid/cfg_ready | quantum, 16 bits
//
// Load, clear and unused codes are handled in the idle state. A step stalls the input
// until its result is registered: the table is read
// one entry per cycle through the single RAM read port, the read drains,
// then four arithmetic stages (time, turnaround, waiting, sums) and the output cycle.
// A step with nothing left to run goes straight to the output cycle.
// Reset empties the table at once; table contents stay stale until loaded.
// A stalled output holds the last result; the input is taken meanwhile until
// a step needs the output register.
module round_robin_quantum_scheduler_core import rrqs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_TAT,
    S_WAIT,
    S_SUM,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PID_W-1:0]     scan_r, scan_nxt;
  logic [31:0]          time_r, time_nxt;
  logic [39:0]          tsum_r, tsum_nxt;
  logic [39:0]          wsum_r, wsum_nxt;
  logic [15:0]          quantum_r, quantum_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt;
  logic [PID_W-1:0]     iss_idx_r, iss_idx_nxt;
  logic [CNT_W-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [PID_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [PID_W-1:0]     pid_r, pid_nxt;
  entry_t               ent_r, ent_nxt;
  logic                 fin_r, fin_nxt;
  logic [31:0]          tat_r, tat_nxt;
  logic [31:0]          wt_r, wt_nxt;
  logic                 alldone_r, alldone_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_r, out_nxt;

  logic                 in_acc;
  logic                 scan_start;
  logic [MAX_PROCS-1:0] live_mask;
  logic                 any_open;
  logic [PID_W-1:0]     start_idx;

  logic                 ram_we;
  logic [PID_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [PID_W-1:0]     ram_raddr;
  entry_t               ram_rdata;

  scan_res_t            res;

  logic [PID_W-1:0]     exec_pid;
  entry_t               exec_ent;
  logic [31:0]          exec_base;
  logic [15:0]          exec_q;
  logic                 exec_fin;
  logic [32:0]          time_sum;
  logic [40:0]          tsum_add;
  logic [40:0]          wsum_add;

  rrqs_ram #(
    .W (ENT_W),
    .D (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrqs_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .rd_vld     (rd_vld_r),
    .rd_idx     (rd_idx_r),
    .rd_ent     (ram_rdata),
    .done_marks (done_r),
    .cur_time   (time_r),
    .res        (res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      live_mask[i] = (CNT_W'(i) < count_r);
    end
  end

  assign any_open  = |(live_mask & ~done_r);
  assign start_idx = (CNT_W'(scan_r) < count_r) ? scan_r : '0;

  // Slice selection: ready entry if any, else jump to the earliest arrival.
  assign exec_pid  = res.found ? res.sel_idx : res.min_idx;
  assign exec_ent  = res.found ? res.sel_ent : res.min_ent;
  assign exec_base = res.found ? time_r : {16'd0, res.min_ent.arrival};
  assign exec_q    = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign exec_fin  = (exec_ent.remaining <= exec_q);
  assign time_sum  = {1'b0, exec_base} + {17'd0, (exec_fin ? exec_ent.remaining : exec_q)};
  assign tsum_add  = {1'b0, tsum_r} + {9'd0, tat_r};
  assign wsum_add  = {1'b0, wsum_r} + {9'd0, wt_r};

  assign scan_start = in_acc && (func_t'(in_data.func) == FUNC_STEP);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    time_nxt    = time_r;
    tsum_nxt    = tsum_r;
    wsum_nxt    = wsum_r;
    quantum_nxt = quantum_r;
    done_nxt    = done_r;
    iss_idx_nxt = iss_idx_r;
    iss_cnt_nxt = iss_cnt_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = iss_idx_r;
    pid_nxt     = pid_r;
    ent_nxt     = ent_r;
    fin_nxt     = fin_r;
    tat_nxt     = tat_r;
    wt_nxt      = wt_r;
    alldone_nxt = alldone_r;
    out_vld_nxt = out_vld_r && out_stall;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[PID_W-1:0];
    ram_wdata   = '{arrival: in_data.arrival_time, burst: in_data.burst_time,
                    remaining: in_data.burst_time};
    ram_raddr   = iss_idx_r;

    if (cfg_valid && cfg_ready) begin
      quantum_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_t'(in_data.func))
            FUNC_LOAD: begin
              if (count_r < CNT_W'(MAX_PROCS)) begin
                ram_we                          = 1'b1;
                done_nxt[count_r[PID_W-1:0]]    = 1'b0;
                count_nxt                       = count_r + CNT_W'(1);
              end
            end
            FUNC_STEP: begin
              if (any_open) begin
                alldone_nxt = 1'b0;
                iss_idx_nxt = start_idx;
                iss_cnt_nxt = '0;
                state_nxt   = S_SCAN;
              end else begin
                alldone_nxt = 1'b1;
                state_nxt   = S_EMIT;
              end
            end
            FUNC_CLEAR: begin
              done_nxt  = '0;
              count_nxt = '0;
              scan_nxt  = '0;
              time_nxt  = '0;
              tsum_nxt  = '0;
              wsum_nxt  = '0;
            end
            FUNC_NONE: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (iss_cnt_r < count_r) begin
          // issue the next circular read
          rd_vld_nxt  = 1'b1;
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
          iss_idx_nxt = ((CNT_W'(iss_idx_r) + CNT_W'(1)) == count_r) ? '0
                        : iss_idx_r + PID_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        time_nxt = time_sum[32] ? '1 : time_sum[31:0];
        pid_nxt  = exec_pid;
        ent_nxt  = exec_ent;
        fin_nxt  = exec_fin;
        ram_we    = 1'b1;
        ram_waddr = exec_pid;
        ram_wdata = '{arrival: exec_ent.arrival, burst: exec_ent.burst,
                      remaining: exec_fin ? 16'd0 : exec_ent.remaining - exec_q};
        if (exec_fin) begin
          done_nxt[exec_pid] = 1'b1;
        end
        scan_nxt  = ((CNT_W'(exec_pid) + CNT_W'(1)) == count_r) ? '0
                    : exec_pid + PID_W'(1);
        state_nxt = S_TAT;
      end

      S_TAT: begin
        tat_nxt   = fin_r ? (time_r - {16'd0, ent_r.arrival}) : 32'd0;
        state_nxt = S_WAIT;
      end

      S_WAIT: begin
        wt_nxt    = (tat_r >= {16'd0, ent_r.burst}) ? tat_r - {16'd0, ent_r.burst} : 32'd0;
        tsum_nxt  = tsum_add[40] ? '1 : tsum_add[39:0];
        state_nxt = S_SUM;
      end

      S_SUM: begin
        wsum_nxt  = wsum_add[40] ? '1 : wsum_add[39:0];
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // hold until the output register is free
        if (!out_vld_r || !out_stall) begin
          out_vld_nxt                = 1'b1;
          out_nxt.process_id         = alldone_r ? 4'd0 : 4'(pid_r);
          out_nxt.slice_end_time     = time_r;
          out_nxt.finished           = !alldone_r && fin_r;
          out_nxt.turnaround         = alldone_r ? 32'd0 : tat_r;
          out_nxt.waiting            = alldone_r ? 32'd0 : wt_r;
          out_nxt.all_done           = alldone_r;
          out_nxt.total_turnaround   = tsum_r;
          out_nxt.total_waiting      = wsum_r;
          out_nxt.process_count      = 5'(count_r);
          state_nxt                  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      scan_r    <= '0;
      time_r    <= '0;
      tsum_r    <= '0;
      wsum_r    <= '0;
      quantum_r <= QUANTUM_RST;
      done_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      alldone_r <= 1'b0;
      iss_cnt_r <= '0;
      iss_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      scan_r    <= scan_nxt;
      time_r    <= time_nxt;
      tsum_r    <= tsum_nxt;
      wsum_r    <= wsum_nxt;
      quantum_r <= quantum_nxt;
      done_r    <= done_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      alldone_r <= alldone_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      iss_idx_r <= iss_idx_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    pid_r    <= pid_nxt;
    ent_r    <= ent_nxt;
    fin_r    <= fin_nxt;
    tat_r    <= tat_nxt;
    wt_r     <= wt_nxt;
    out_r    <= out_nxt;
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> count_r != '0)
    else $error("scan started on an empty table");

  a_exec_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> (res.found || res.min_vld) && !done_r[exec_pid])
    else $error("slice selected no open process");

  a_done_marked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && exec_fin |=> done_r[$past(exec_pid)])
    else $error("finished process not marked done");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCS))
    else $error("process count beyond table depth");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && (!out_vld_r || !out_stall) |=> out_vld_r && state_r == S_IDLE)
    else $error("result not presented after step");

endmodule

[src/rrqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrqs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/rrqs_scan.sv]
// Scan unit: tracks first ready process and earliest pending arrival from the read stream.
module rrqs_scan import rrqs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 rd_vld,
  input  logic [PID_W-1:0]     rd_idx,
  input  entry_t               rd_ent,
  input  logic [MAX_PROCS-1:0] done_marks,
  input  logic [31:0]          cur_time,
  output scan_res_t            res
);

  scan_res_t res_r, res_nxt;

  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt.found   = 1'b0;
      res_nxt.min_vld = 1'b0;
    end else if (rd_vld && !done_marks[rd_idx]) begin
      // first ready entry in circular order wins
      if (!res_r.found && ({16'd0, rd_ent.arrival} <= cur_time)) begin
        res_nxt.found   = 1'b1;
        res_nxt.sel_idx = rd_idx;
        res_nxt.sel_ent = rd_ent;
      end
      // strict compare keeps the first entry that reaches the minimum
      if (!res_r.min_vld || (rd_ent.arrival < res_r.min_ent.arrival)) begin
        res_nxt.min_vld = 1'b1;
        res_nxt.min_idx = rd_idx;
        res_nxt.min_ent = rd_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.found   <= 1'b0;
      res_r.min_vld <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[verif/round_robin_quantum_scheduler_core_tb.sv]
// Self-checking testbench for the round-robin quantum scheduler core.
module round_robin_quantum_scheduler_core_tb;
  import rrqs_pkg::*;

  localparam int     CYCLE_LIMIT = 600000;
  localparam int     DRAIN_SLACK = 40;
  localparam int     HOLD_CYCLES = 400;
  localparam int     N_PHASES    = 8;
  localparam int     PHASE_ITEMS = 225;
  localparam int     STEP_CAP    = 60;
  localparam longint TIME_MAX    = 64'hFFFF_FFFF;
  localparam longint SUM_MAX     = 64'hFF_FFFF_FFFF;

  localparam out_item_t EMPTY_REPORT =
    '{4'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1, 40'd0, 40'd0, 5'd0};

  typedef struct packed {
    func_t       op;
    logic [15:0] arr;
    logic [15:0] bur;
    logic [4:0]  reps;
    logic        typed;
    out_item_t   want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // scheduler state as predicted
  logic [15:0] proc_arrival [MAX_PROCS];
  logic [15:0] proc_burst   [MAX_PROCS];
  logic [15:0] proc_left    [MAX_PROCS];
  logic        proc_done    [MAX_PROCS];
  int          n_loaded;
  int          next_scan;
  longint      now_time;
  longint      tat_total;
  longint      wait_total;
  logic [15:0] slice_len;

  out_item_t   pending_reports [$];
  int          mismatch_count = 0;
  int          reports_seen   = 0;
  int          cycle_count    = 0;
  int          n_loads = 0, n_steps = 0, n_clears = 0, n_unused = 0, n_completed = 0;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;

  round_robin_quantum_scheduler_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat_add(input longint a, input longint b, input longint lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic int find_ready(input int start);
    int idx;
    for (int k = 0; k < n_loaded; k++) begin
      idx = (start + k) % n_loaded;
      if (!proc_done[idx] && proc_arrival[idx] <= now_time) return idx;
    end
    return -1;
  endfunction

  task automatic clear_sched();
    for (int k = 0; k < MAX_PROCS; k++) proc_done[k] = 1'b0;
    n_loaded   = 0;
    next_scan  = 0;
    now_time   = 0;
    tat_total  = 0;
    wait_total = 0;
  endtask

  // Apply one accepted transaction to the predicted state; return its slice report.
  task automatic schedule_item(input in_item_t it, output bit has_rep, output out_item_t rep);
    int     k, start, sel, q;
    longint earliest, tat, wt;
    bit     any_left;
    has_rep = 1'b0;
    rep     = '0;
    case (it.func)
      FUNC_LOAD: begin
        n_loads++;
        if (n_loaded < MAX_PROCS) begin
          proc_arrival[n_loaded] = it.arrival_time;
          proc_burst[n_loaded]   = it.burst_time;
          proc_left[n_loaded]    = it.burst_time;
          proc_done[n_loaded]    = 1'b0;
          n_loaded++;
        end
      end
      FUNC_CLEAR: begin
        n_clears++;
        clear_sched();
      end
      FUNC_STEP: begin
        n_steps++;
        has_rep  = 1'b1;
        any_left = 1'b0;
        earliest = 0;
        for (k = 0; k < n_loaded; k++) begin
          if (!proc_done[k]) begin
            if (!any_left || proc_arrival[k] < earliest) earliest = proc_arrival[k];
            any_left = 1'b1;
          end
        end
        if (any_left) begin
          start = (next_scan < n_loaded) ? next_scan : 0;
          sel   = find_ready(start);
          // nothing has arrived: advance the clock to the earliest pending arrival
          if (sel < 0 && earliest > now_time) begin
            now_time = earliest;
            sel      = find_ready(start);
          end
          if (sel < 0) begin
            has_rep = 1'b0;
            return;
          end
          q = (slice_len == 0) ? 1 : int'(slice_len);
          if (proc_left[sel] <= q) begin
            now_time       = sat_add(now_time, proc_left[sel], TIME_MAX);
            proc_left[sel] = '0;
            proc_done[sel] = 1'b1;
            tat            = now_time - proc_arrival[sel];
            wt             = (tat >= proc_burst[sel]) ? tat - proc_burst[sel] : 0;
            tat_total      = sat_add(tat_total, tat, SUM_MAX);
            wait_total     = sat_add(wait_total, wt, SUM_MAX);
            rep.finished   = 1'b1;
            rep.turnaround = tat[31:0];
            rep.waiting    = wt[31:0];
            n_completed++;
          end else begin
            now_time       = sat_add(now_time, q, TIME_MAX);
            proc_left[sel] = proc_left[sel] - 16'(q);
          end
          next_scan      = (sel + 1) % n_loaded;
          rep.process_id = 4'(sel);
        end else begin
          rep.all_done = 1'b1;
        end
        rep.slice_end_time   = now_time[31:0];
        rep.total_turnaround = tat_total[39:0];
        rep.total_waiting    = wait_total[39:0];
        rep.process_count    = 5'(n_loaded);
      end
      default: n_unused++;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp);
    $display("mismatch at report %0d (cycle %0d): %s got %0h, want %0h",
             reports_seen, cycle_count, what, got, exp);
    mismatch_count++;
  endtask

  // Offer one transaction; hold it until taken, then predict.
  task automatic send_item(input func_t op, input logic [15:0] arr, input logic [15:0] bur,
                           input bit typed, input out_item_t want);
    in_item_t  it;
    out_item_t rep;
    bit        has_rep;
    it.func         = op;
    it.arrival_time = arr;
    it.burst_time   = bur;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_item(it, has_rep, rep);
    if (has_rep) pending_reports.push_back(typed ? want : rep);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_for_reports();
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_quantum(input logic [15:0] value);
    wait_for_reports();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slice_len = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        note_mismatch("report with nothing pending, process_id", out_data.process_id, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_data.process_id !== want.process_id)
          note_mismatch("process_id", out_data.process_id, want.process_id);
        if (out_data.slice_end_time !== want.slice_end_time)
          note_mismatch("slice_end_time", out_data.slice_end_time, want.slice_end_time);
        if (out_data.finished !== want.finished)
          note_mismatch("finished", out_data.finished, want.finished);
        if (out_data.turnaround !== want.turnaround)
          note_mismatch("turnaround", out_data.turnaround, want.turnaround);
        if (out_data.waiting !== want.waiting)
          note_mismatch("waiting", out_data.waiting, want.waiting);
        if (out_data.all_done !== want.all_done)
          note_mismatch("all_done", out_data.all_done, want.all_done);
        if (out_data.total_turnaround !== want.total_turnaround)
          note_mismatch("total_turnaround", out_data.total_turnaround, want.total_turnaround);
        if (out_data.total_waiting !== want.total_waiting)
          note_mismatch("total_waiting", out_data.total_waiting, want.total_waiting);
        if (out_data.process_count !== want.process_count)
          note_mismatch("process_count", out_data.process_count, want.process_count);
      end
    end
  end

  // receiver back-pressure: random bursts, plus one long hold on request
  initial begin : out_stall_gen
    int run_left  = 0;
    bit run_stall = 1'b0;
    int hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          run_left  = run_stall ? $urandom_range(1, 9) : $urandom_range(1, 30);
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   directed_plan [10];
    logic [15:0] q_plan [N_PHASES];
    logic [15:0] arr;
    int          phase, sent, n, k, b, q, need, pick;

    directed_plan = '{
      '{FUNC_STEP,  16'd0,     16'd0,     5'd1,  1'b1, EMPTY_REPORT},
      '{FUNC_NONE,  16'hFFFF,  16'hFFFF,  5'd1,  1'b0, '0},
      '{FUNC_LOAD,  16'd10,    16'd6,     5'd1,  1'b0, '0},
      '{FUNC_LOAD,  16'd12,    16'd0,     5'd1,  1'b0, '0},
      '{FUNC_LOAD,  16'hFFFF,  16'hFFFF,  5'd1,  1'b0, '0},
      // late start, zero burst, wrap-around, far jump in time
      '{FUNC_STEP,  16'd0,     16'd0,     5'd4,  1'b0, '0},
      // fill the table; the last load falls off
      '{FUNC_LOAD,  16'd0,     16'd1,     5'd14, 1'b0, '0},
      '{FUNC_STEP,  16'hFFFF,  16'hFFFF,  5'd1,  1'b0, '0},
      '{FUNC_CLEAR, 16'hFFFF,  16'hFFFF,  5'd1,  1'b0, '0},
      '{FUNC_STEP,  16'd0,     16'd0,     5'd1,  1'b1, EMPTY_REPORT}
    };
    q_plan = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 12)),
               16'($urandom_range(1, 65535)), 16'd2, 16'($urandom_range(3, 40)),
               QUANTUM_RST};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    clear_sched();
    slice_len = QUANTUM_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i])
      repeat (directed_plan[i].reps)
        send_item(directed_plan[i].op, directed_plan[i].arr, directed_plan[i].bur,
                  directed_plan[i].typed, directed_plan[i].want);

    for (phase = 0; phase < N_PHASES; phase++) begin
      go_idle();
      write_quantum(q_plan[phase]);
      idle_on = (phase != N_PHASES - 1);
      if (phase == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) != 0) begin
          // job set: clear (most times), load, then slices to drain it, capped near STEP_CAP
          if ($urandom_range(0, 3) != 0) begin
            send_item(FUNC_CLEAR, 16'($urandom()), 16'($urandom()), 1'b0, '0);
            sent++;
          end
          n    = ($urandom_range(0, 9) == 0) ? MAX_PROCS + 2 : $urandom_range(1, MAX_PROCS);
          q    = (slice_len == 0) ? 1 : int'(slice_len);
          need = 2;
          for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 3);
            arr  = (pick < 2) ? 16'($urandom_range(0, 40)) :
                   (pick == 2) ? 16'($urandom_range(0, 1000)) : 16'($urandom());
            pick = $urandom_range(0, 19);
            b    = (pick < 12) ? $urandom_range(0, 12) :
                   (pick < 17) ? $urandom_range(0, 200) : $urandom_range(0, 65535);
            need += (b == 0) ? 1 : (b + q - 1) / q;
            send_item(FUNC_LOAD, arr, 16'(b), 1'b0, '0);
          end
          if (need > STEP_CAP) need = STEP_CAP;
          need += $urandom_range(0, 2);
          repeat (need) send_item(FUNC_STEP, 16'($urandom()), 16'($urandom()), 1'b0, '0);
          sent += n + need;
        end else begin
          n = $urandom_range(1, 6);
          repeat (n)
            send_item(func_t'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
                      1'b0, '0);
          sent += n;
        end
      end
    end

    go_idle();
    wait_for_reports();
    if (pending_reports.size() != 0)
      note_mismatch("reports never delivered", pending_reports.size(), 0);
    $display("Exercised %0d loads, %0d slices, %0d clears, %0d unused codes over %0d quanta",
             n_loads, n_steps, n_clears, n_unused, N_PHASES + 1);
    $display("Compared %0d slice reports, %0d processes completed, %0d mismatches",
             reports_seen, n_completed, mismatch_count);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
src/rrqs_pkg.sv
src/rrqs_ram.sv
src/rrqs_scan.sv
src/round_robin_quantum_scheduler_core.sv
verif/round_robin_quantum_scheduler_core_tb.sv
